// ----- hw/rtl/ols_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg: shared types and constants of the ordered list store
// Holds the operation, status and sequencer state codes and the defaults.
// ----------------------------------------------------------------------------
package ols_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;
    localparam int OP_BITS        = 4;
    localparam int IN_VAL_BITS    = 32;
    localparam int POS_BITS       = 8;
    localparam int STATUS_BITS    = 2;

    localparam logic [OP_BITS-1:0] OP_ADD_FIRST  = 4'd0;
    localparam logic [OP_BITS-1:0] OP_ADD_LAST   = 4'd1;
    localparam logic [OP_BITS-1:0] OP_ADD_MIDDLE = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DEL_FIRST  = 4'd3;
    localparam logic [OP_BITS-1:0] OP_DEL_LAST   = 4'd4;
    localparam logic [OP_BITS-1:0] OP_DEL_MIDDLE = 4'd5;
    localparam logic [OP_BITS-1:0] OP_CLEAR      = 4'd6;
    localparam logic [OP_BITS-1:0] OP_CONTAINS   = 4'd7;
    localparam logic [OP_BITS-1:0] OP_GET        = 4'd8;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN_RD,
        S_OPEN_WR,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_SCAN,
        S_GET,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/ols_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ols_req_if / ols_rsp_if: request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface ols_req_if;
    logic                              valid;
    logic                              ready;
    logic [ols_pkg::OP_BITS-1:0]       op;
    logic signed [ols_pkg::IN_VAL_BITS-1:0] item_value;
    logic [ols_pkg::POS_BITS-1:0]      position;
    modport source (output valid, op, item_value, position, input ready);
    modport sink   (input valid, op, item_value, position, output ready);
endinterface

interface ols_rsp_if #(parameter int CAPACITY = ols_pkg::CAPACITY_DEF);
    logic                                   valid;
    logic                                   ready;
    logic signed [ols_pkg::IN_VAL_BITS-1:0] read_value;
    logic                                   found;
    logic [ols_pkg::STATUS_BITS-1:0]        status;
    logic [$clog2(CAPACITY+1)-1:0]          count;
    modport source (output valid, read_value, found, status, count, input ready);
    modport sink   (input valid, read_value, found, status, count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ols_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ols_mem: element storage
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module ols_mem #(
    parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ols_pkg::VALUE_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire [$clog2(CAPACITY)-1:0]  i_waddr,
    input  wire [VALUE_BITS-1:0]        i_wdata,
    input  wire [$clog2(CAPACITY)-1:0]  i_raddr,
    output logic [VALUE_BITS-1:0]       o_rdata
);
    logic [VALUE_BITS-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ordered_list_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list of values
// Adds, deletes, searches, reads and clears a packed list held in one memory.
// ----------------------------------------------------------------------------
// Usage: requests (op, item_value, position) arrive on i_req; each request
// gives exactly one result (read_value, found, status, count) on o_rsp.
// The block takes one request at a time. Ready is low from the transfer of
// a request until its result has been transferred out.
// Add and delete move one element at a time through the single memory
// port pair (read, then write); contains scans one element a cycle; get
// reads the addressed entry; clear, rejected requests and no-op codes go
// straight to the result.
// The result is held in the output register while the receiver stalls.
// Reset clears the count and the sequencer; the memory is not cleared,
// since only entries below the count are read.
// ----------------------------------------------------------------------------
module ordered_list_store #(
    parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ols_pkg::VALUE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ols_req_if.sink     i_req,
    ols_rsp_if.source   o_rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int IVB = ols_pkg::IN_VAL_BITS;

    ols_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;     // walking index
    logic [CW-1:0]  r_stop, n_stop;   // target position
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IVB-1:0] r_rd, n_rd;
    logic r_found, n_found;
    logic [ols_pkg::STATUS_BITS-1:0] r_status, n_status;
    logic r_scan_v, n_scan_v;         // read data valid during scan

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;
    logic [VALUE_BITS-1:0] in_val;
    logic [CW-1:0]   mid_add, mid_del;

    ols_mem #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign in_val = VALUE_BITS'({{64-IVB{i_req.item_value[IVB-1]}}, i_req.item_value});
    assign mid_add = (r_count < CW'(2)) ? r_count : (r_count >> 1);
    assign mid_del = (r_count < CW'(3)) ? CW'(r_count != CW'(0))
                                        : ((r_count - CW'(1)) >> 1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_stop   = r_stop;
        n_val    = r_val;
        n_rd     = r_rd;
        n_found  = r_found;
        n_status = r_status;
        n_scan_v = 1'b0;
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = r_val;
        raddr = r_idx[AW-1:0];
        case (r_state)
            ols_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_val = in_val;
                    n_rd = '0;
                    n_found = 1'b0;
                    n_status = ols_pkg::ST_OK;
                    n_state = ols_pkg::S_DONE;
                    case (i_req.op)
                        ols_pkg::OP_ADD_FIRST, ols_pkg::OP_ADD_LAST,
                        ols_pkg::OP_ADD_MIDDLE: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ols_pkg::ST_FULL;
                            end else begin
                                if (i_req.op == ols_pkg::OP_ADD_FIRST) n_stop = '0;
                                else if (i_req.op == ols_pkg::OP_ADD_LAST) n_stop = r_count;
                                else n_stop = mid_add;
                                n_idx = r_count;
                                n_state = ols_pkg::S_OPEN_RD;
                            end
                        end
                        ols_pkg::OP_DEL_FIRST, ols_pkg::OP_DEL_LAST,
                        ols_pkg::OP_DEL_MIDDLE: begin
                            if (r_count != CW'(0)) begin
                                if (i_req.op == ols_pkg::OP_DEL_FIRST || r_count == CW'(1))
                                    n_idx = '0;
                                else if (i_req.op == ols_pkg::OP_DEL_LAST)
                                    n_idx = r_count - CW'(1);
                                else n_idx = mid_del;
                                n_state = ols_pkg::S_CLOSE_RD;
                            end
                        end
                        ols_pkg::OP_CLEAR: n_count = '0;
                        ols_pkg::OP_CONTAINS: begin
                            n_idx = '0;
                            n_stop = '0;
                            n_state = ols_pkg::S_SCAN;
                        end
                        ols_pkg::OP_GET: begin
                            if (32'(i_req.position) < 32'(r_count)) begin
                                n_idx = CW'(i_req.position);
                                n_state = ols_pkg::S_GET;
                            end else begin
                                n_status = ols_pkg::ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Shift up: read entry idx-1, write it to idx, stop at target.
            ols_pkg::S_OPEN_RD: begin
                if (r_idx == r_stop) begin
                    we = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = ols_pkg::S_DONE;
                end else begin
                    raddr = AW'(r_idx - CW'(1));
                    n_state = ols_pkg::S_OPEN_WR;
                end
            end
            ols_pkg::S_OPEN_WR: begin
                we = 1'b1;
                wdata = rdata;
                n_idx = r_idx - CW'(1);
                n_state = ols_pkg::S_OPEN_RD;
            end
            // Shift down: read entry idx+1, write it to idx.
            ols_pkg::S_CLOSE_RD: begin
                if (r_idx + CW'(1) >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = ols_pkg::S_DONE;
                end else begin
                    raddr = AW'(r_idx + CW'(1));
                    n_state = ols_pkg::S_CLOSE_WR;
                end
            end
            ols_pkg::S_CLOSE_WR: begin
                we = 1'b1;
                wdata = rdata;
                n_idx = r_idx + CW'(1);
                n_state = ols_pkg::S_CLOSE_RD;
            end
            // r_idx addresses reads; rdata holds the entry at r_idx-1.
            ols_pkg::S_SCAN: begin
                if (r_scan_v && rdata == r_val) begin
                    n_found = 1'b1;
                    n_state = ols_pkg::S_DONE;
                end else if (r_idx >= r_count) begin
                    n_state = ols_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_scan_v = 1'b1;
                end
            end
            ols_pkg::S_GET: begin
                if (r_scan_v) begin
                    n_rd = IVB'(64'(rdata));
                    n_state = ols_pkg::S_DONE;
                end else begin
                    n_scan_v = 1'b1;
                end
            end
            ols_pkg::S_DONE: begin
                if (o_rsp.ready) n_state = ols_pkg::S_IDLE;
            end
            default: n_state = ols_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ols_pkg::S_IDLE;
            r_count  <= '0;
            r_scan_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_scan_v <= n_scan_v;
        end
        r_idx    <= n_idx;
        r_stop   <= n_stop;
        r_val    <= n_val;
        r_rd     <= n_rd;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign i_req.ready      = (r_state == ols_pkg::S_IDLE);
    assign o_rsp.valid      = (r_state == ols_pkg::S_DONE);
    assign o_rsp.read_value = r_rd;
    assign o_rsp.found      = r_found;
    assign o_rsp.status     = r_status;
    assign o_rsp.count      = r_count;
endmodule
`default_nettype wire

// ----- hw/rtl/ols_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ols_checker: port-level checks of the ordered list store
// Watches the request and result channels at the top level ports.
// ----------------------------------------------------------------------------
module ols_checker #(
    parameter int CW = 9
) (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          req_valid,
    input wire          req_ready,
    input wire          rsp_valid,
    input wire          rsp_ready,
    input wire [1:0]    rsp_status,
    input wire          rsp_found,
    input wire [CW-1:0] rsp_count
);
    // No new request is taken while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while result pending");
    // A request transfer is followed by a busy cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready) else $error("ready held after transfer");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
        else $error("result dropped under stall");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_found |-> rsp_status == ols_pkg::ST_OK && rsp_count != '0)
        else $error("found with bad status or empty list");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_status <= ols_pkg::ST_FULL) else $error("illegal status");
endmodule

bind ordered_list_store ols_checker #(.CW($clog2(CAPACITY+1))) u_ols_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_status(o_rsp.status), .rsp_found(o_rsp.found), .rsp_count(o_rsp.count)
);
`default_nettype wire
